>>> rtl/core/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// types and fixed widths shared by the triangle face normal unit
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int TAG_BITS        = 16;
    localparam int COORD_BITS      = 32;
    localparam int OUT_BITS        = 32;
    localparam int NORMAL_FRAC_DEF = 30;

    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * EDGE_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int MAG_BITS   = PROD_BITS;
    localparam int HALF_BITS  = MAG_BITS / 2;
    localparam int MSQ_BITS   = 2 * MAG_BITS;
    localparam int SUM_BITS   = MSQ_BITS + 2;

    typedef struct packed {
        logic        [TAG_BITS-1:0]   tri_tag;
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
    } tfn_in_t;

    typedef struct packed {
        logic        [TAG_BITS-1:0] out_tag;
        logic signed [OUT_BITS-1:0] normal_x;
        logic signed [OUT_BITS-1:0] normal_y;
        logic signed [OUT_BITS-1:0] normal_z;
        logic                       degenerate;
    } tfn_out_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic                degen;
        logic [2:0]          neg;
    } tfn_side_t;

endpackage

>>> rtl/core/triangle_face_normal_unit.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// cross product of two triangle edges, scaled to a rounded unit normal
//
//   channel   signals                       carries
//   in        in_valid in_ready in_data     one triangle request
//   out       out_valid out_ready out_data  tag, normal, degenerate flag
//
// one request per cycle while in_ready is high; the pipeline is built from
// six front stages, the restoring divider (2*NORMAL_FRAC+3 stages), the square
// root (NORMAL_FRAC+2 stages) and the output register, one result bit per divider or root stage
// reset clears every stage valid bit and the output and skid valid bits
// a stalled output parks one result in the skid register; the pipeline
// freezes only while that register is full
// ----------------------------------------------------------------------------
module triangle_face_normal_unit #(
    parameter int NORMAL_FRAC = tfn_pkg::NORMAL_FRAC_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tfn_pkg::tfn_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tfn_pkg::tfn_out_t out_data
);
    import tfn_pkg::*;

    localparam int QW  = 2 * NORMAL_FRAC + 3;
    localparam int DS  = QW;
    localparam int QE  = QW + 1;
    localparam int RW  = QE / 2;
    localparam int RMW = RW + 2;
    localparam int XW  = (RW + 1 > OUT_BITS) ? RW + 1 : OUT_BITS;

    logic en;

    logic signed [COORD_BITS-1:0] ca [3];
    logic signed [COORD_BITS-1:0] cb [3];
    logic signed [COORD_BITS-1:0] cc [3];

    // edges
    logic                        e_valid_reg;
    tfn_side_t                   e_side_reg;
    logic signed [EDGE_BITS-1:0] e1_reg [3];
    logic signed [EDGE_BITS-1:0] e2_reg [3];

    // products
    logic                        p_valid_reg;
    tfn_side_t                   p_side_reg;
    logic signed [PROD_BITS-1:0] t1_reg [3];
    logic signed [PROD_BITS-1:0] t2_reg [3];

    // cross magnitude
    logic                        c_valid_reg;
    tfn_side_t                   c_side_reg;
    logic        [MAG_BITS-1:0]  m_reg [3];
    logic signed [CROSS_BITS-1:0] n_next [3];
    logic        [CROSS_BITS-1:0] mf_next [3];

    // partial squares
    logic                          h_valid_reg;
    tfn_side_t                     h_side_reg;
    logic [2*HALF_BITS-1:0]        hh_reg [3];
    logic [2*HALF_BITS-1:0]        hl_reg [3];
    logic [2*HALF_BITS-1:0]        ll_reg [3];

    // squares
    logic                 q_valid_reg;
    tfn_side_t            q_side_reg;
    logic [MSQ_BITS-1:0]  m2_reg [3];

    // sum of squares
    logic                 s_valid_reg;
    tfn_side_t            s_side_reg;
    logic [MSQ_BITS-1:0]  sm2_reg [3];
    logic [SUM_BITS-1:0]  s_reg;

    // divider
    logic                 dv_valid_reg [DS];
    tfn_side_t            dv_side_reg  [DS];
    logic [SUM_BITS-1:0]  dv_s_reg     [DS];
    logic [SUM_BITS-1:0]  dv_rem_reg   [DS][3];
    logic [QW-1:0]        dv_q_reg     [DS][3];

    // square root
    logic                 sr_valid_reg [RW];
    tfn_side_t            sr_side_reg  [RW];
    logic [QE-1:0]        sr_q_reg     [RW][3];
    logic [RMW-1:0]       sr_rem_reg   [RW][3];
    logic [RW-1:0]        sr_root_reg  [RW][3];

    // output
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    tfn_out_t  out_data_reg, out_data_next;
    tfn_out_t  skid_data_reg, skid_data_next;
    logic      fin_valid;
    tfn_out_t  fin_data;
    logic [OUT_BITS-1:0] fin_n [3];

    assign en       = ~skid_valid_reg;
    assign in_ready = en;

    assign ca[0] = in_data.a_x;
    assign ca[1] = in_data.a_y;
    assign ca[2] = in_data.a_z;
    assign cb[0] = in_data.b_x;
    assign cb[1] = in_data.b_y;
    assign cb[2] = in_data.b_z;
    assign cc[0] = in_data.c_x;
    assign cc[1] = in_data.c_y;
    assign cc[2] = in_data.c_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_next[i]  = CROSS_BITS'(t1_reg[i]) - CROSS_BITS'(t2_reg[i]);
            mf_next[i] = n_next[i][CROSS_BITS-1] ? -n_next[i] : n_next[i];
        end
    end

    // front stages, valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= in_valid;
            p_valid_reg <= e_valid_reg;
            c_valid_reg <= p_valid_reg;
            h_valid_reg <= c_valid_reg;
            q_valid_reg <= h_valid_reg;
            s_valid_reg <= q_valid_reg;
        end
    end

    // front stages, payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_side_reg <= '{tag: in_data.tri_tag, degen: 1'b0, neg: 3'b000};
            p_side_reg <= e_side_reg;
            c_side_reg <= '{tag: p_side_reg.tag, degen: 1'b0,
                            neg: {n_next[2][CROSS_BITS-1], n_next[1][CROSS_BITS-1],
                                  n_next[0][CROSS_BITS-1]}};
            h_side_reg <= c_side_reg;
            q_side_reg <= h_side_reg;
            s_side_reg <= q_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EDGE_BITS'(cb[i]) - EDGE_BITS'(ca[i]);
                e2_reg[i] <= EDGE_BITS'(cc[i]) - EDGE_BITS'(ca[i]);
                t1_reg[i] <= e1_reg[(i + 1) % 3] * e2_reg[(i + 2) % 3];
                t2_reg[i] <= e1_reg[(i + 2) % 3] * e2_reg[(i + 1) % 3];
                m_reg[i]  <= mf_next[i][MAG_BITS-1:0];
                hh_reg[i] <= m_reg[i][MAG_BITS-1:HALF_BITS] * m_reg[i][MAG_BITS-1:HALF_BITS];
                hl_reg[i] <= m_reg[i][MAG_BITS-1:HALF_BITS] * m_reg[i][HALF_BITS-1:0];
                ll_reg[i] <= m_reg[i][HALF_BITS-1:0] * m_reg[i][HALF_BITS-1:0];
                m2_reg[i] <= (MSQ_BITS'(hh_reg[i]) << (2 * HALF_BITS))
                           + (MSQ_BITS'(hl_reg[i]) << (HALF_BITS + 1))
                           + MSQ_BITS'(ll_reg[i]);
                sm2_reg[i] <= m2_reg[i];
            end
            s_reg <= SUM_BITS'(m2_reg[0]) + SUM_BITS'(m2_reg[1]) + SUM_BITS'(m2_reg[2]);
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar g = 0; g < DS; g++)
    begin : g_div
        logic [SUM_BITS:0]   pr [3];
        logic [SUM_BITS:0]   df [3];
        logic                ge [3];
        logic [SUM_BITS-1:0] sv;
        logic                vin;
        tfn_side_t           sin;
        logic [QW-1:0]       qn [3];

        always_comb
        begin
            if (g == 0)
            begin
                sv        = s_reg;
                vin       = s_valid_reg;
                sin       = s_side_reg;
                sin.degen = (s_reg == '0);
            end
            else
            begin
                sv  = dv_s_reg[(g == 0) ? 0 : g - 1];
                vin = dv_valid_reg[(g == 0) ? 0 : g - 1];
                sin = dv_side_reg[(g == 0) ? 0 : g - 1];
            end
            for (int c = 0; c < 3; c++)
            begin
                if (g == 0)
                begin
                    pr[c] = (SUM_BITS + 1)'(sm2_reg[c]);
                end
                else
                begin
                    pr[c] = {dv_rem_reg[(g == 0) ? 0 : g - 1][c], 1'b0};
                end
                df[c] = pr[c] - {1'b0, sv};
                ge[c] = (pr[c] >= {1'b0, sv});
                if (g == 0)
                begin
                    qn[c] = QW'(ge[c]);
                end
                else
                begin
                    qn[c] = {dv_q_reg[(g == 0) ? 0 : g - 1][c][QW-2:0], ge[c]};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[g] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_side_reg[g] <= sin;
                dv_s_reg[g]    <= sv;
                for (int c = 0; c < 3; c++)
                begin
                    dv_rem_reg[g][c] <= ge[c] ? df[c][SUM_BITS-1:0] : pr[c][SUM_BITS-1:0];
                    dv_q_reg[g][c]   <= qn[c];
                end
            end
        end
    end

    // restoring square root, one root bit per stage
    for (genvar g = 0; g < RW; g++)
    begin : g_sqrt
        logic [QE-1:0]    qi  [3];
        logic [RMW-1:0]   ri  [3];
        logic [RW-1:0]    oi  [3];
        logic [RMW+1:0]   tv  [3];
        logic [RMW+1:0]   tr  [3];
        logic [RMW+1:0]   dfs [3];
        logic             ges [3];
        logic             vin;
        tfn_side_t        sin;

        always_comb
        begin
            if (g == 0)
            begin
                vin = dv_valid_reg[DS-1];
                sin = dv_side_reg[DS-1];
            end
            else
            begin
                vin = sr_valid_reg[(g == 0) ? 0 : g - 1];
                sin = sr_side_reg[(g == 0) ? 0 : g - 1];
            end
            for (int c = 0; c < 3; c++)
            begin
                if (g == 0)
                begin
                    qi[c] = {1'b0, dv_q_reg[DS-1][c]};
                    ri[c] = '0;
                    oi[c] = '0;
                end
                else
                begin
                    qi[c] = sr_q_reg[(g == 0) ? 0 : g - 1][c];
                    ri[c] = sr_rem_reg[(g == 0) ? 0 : g - 1][c];
                    oi[c] = sr_root_reg[(g == 0) ? 0 : g - 1][c];
                end
                tv[c]  = {ri[c], qi[c][QE-1:QE-2]};
                tr[c]  = (RMW + 2)'({oi[c], 2'b01});
                dfs[c] = tv[c] - tr[c];
                ges[c] = (tv[c] >= tr[c]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sr_valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                sr_valid_reg[g] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_side_reg[g] <= sin;
                for (int c = 0; c < 3; c++)
                begin
                    sr_q_reg[g][c]    <= qi[c] << 2;
                    sr_rem_reg[g][c]  <= ges[c] ? dfs[c][RMW-1:0] : tv[c][RMW-1:0];
                    sr_root_reg[g][c] <= {oi[c][RW-2:0], ges[c]};
                end
            end
        end
    end

    // rounding the root to nearest (halves up, last root bit dropped), sign
    always_comb
    begin
        logic [RW:0]   rnd;
        logic [XW-1:0] ext;
        logic [XW-1:0] sgn;
        for (int c = 0; c < 3; c++)
        begin
            rnd      = (RW + 1)'(sr_root_reg[RW-1][c]) + (RW + 1)'(1);
            ext      = XW'(rnd[RW:1]);
            sgn      = sr_side_reg[RW-1].neg[c] ? -ext : ext;
            fin_n[c] = sr_side_reg[RW-1].degen ? '0 : sgn[OUT_BITS-1:0];
        end
        fin_valid           = sr_valid_reg[RW-1];
        fin_data.out_tag    = sr_side_reg[RW-1].tag;
        fin_data.normal_x   = fin_n[0];
        fin_data.normal_y   = fin_n[1];
        fin_data.normal_z   = fin_n[2];
        fin_data.degenerate = sr_side_reg[RW-1].degen;
    end

    // output register with skid
    always_comb
    begin
        logic take;
        take            = out_valid_reg & out_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_next = fin_valid;
            out_data_next  = fin_data;
        end
        else if (fin_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = fin_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
